// ----- hdl/ritb_pkg.sv -----
// Package for the rule image transition blender: widths, register indexes,
// the per-item selection code and the divider step used by the pipeline.
// Depends on nothing; used by rule_image_transition_blend.
package ritb_pkg;

    localparam int PixW     = 32;
    localparam int ChanW    = 8;
    localparam int NumChan  = PixW / ChanW;
    localparam int RuleW    = 8;
    localparam int PhaseW   = 10;
    localparam int LevelW   = 9;
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 10;
    localparam int InDataW  = 2 * PixW + RuleW;
    localparam int NumW     = PhaseW + ChanW;
    localparam int QuoW     = 8;
    localparam int DivSteps = 2;
    localparam int DivStgs  = QuoW / DivSteps;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_PHASE  = 4'd0;
    localparam logic [CfgIdxW-1:0] CFG_RAMP   = 4'd1;
    localparam logic [CfgIdxW-1:0] CFG_LEVEL1 = 4'd2;
    localparam logic [CfgIdxW-1:0] CFG_LEVEL2 = 4'd3;

    // Reset values of the configuration registers
    localparam logic [PhaseW-1:0] PHASE_RST  = 10'd0;
    localparam logic [PhaseW-1:0] RAMP_RST   = 10'd0;
    localparam logic [LevelW-1:0] LEVEL1_RST = 9'd256;
    localparam logic [LevelW-1:0] LEVEL2_RST = 9'd0;

    // Top of the rule range, where the ramp is cut
    localparam logic [LevelW-1:0] RULE_SPAN = 9'd256;
    localparam logic [ChanW-1:0]  W_FULL    = 8'd255;

    // How an item's result is formed
    typedef enum logic [2:0] {
        SEL_FIRST,
        SEL_SECOND,
        SEL_FULL,
        SEL_ZERO,
        SEL_RAMP
    } t_sel;

    // Fields that travel with an item down the pipeline
    typedef struct packed {
        logic [PixW-1:0] p1;
        logic [PixW-1:0] p2;
        logic            eol;
        t_sel            sel;
    } t_item;

    // State of the divider between two of its stages
    typedef struct packed {
        logic [PhaseW-1:0] rem;
        logic [QuoW-1:0]   quo;
        logic [QuoW-1:0]   lo;
    } t_div;

    // One restoring division step: returns {quotient bit, new remainder}.
    function automatic logic [PhaseW:0] div_step(input logic [PhaseW-1:0] rem,
                                                 input logic              nbit,
                                                 input logic [PhaseW-1:0] den);
        logic [PhaseW:0] t;
        logic [PhaseW:0] d;
        t = {rem, nbit};
        d = t - {1'b0, den};
        if (t >= {1'b0, den}) begin
            div_step = {1'b1, d[PhaseW-1:0]};
        end else begin
            div_step = {1'b0, t[PhaseW-1:0]};
        end
    endfunction

endpackage

// ----- hdl/rule_image_transition_blend.sv -----
// Rule image transition blender, top level: eight-stage pixel pipeline.
// Depends on ritb_pkg for widths, register indexes, types and the divider step.
//
// Takes one pixel pair with its rule byte per clock and returns one blended
// pixel per clock once the pipeline is full, unless the output stalls.
// The weight divider is pipelined and resolves two quotient bits in each of its
// four stages. Each stage only waits when the stage after it is full and
// stalled, so gaps in the stream are absorbed and the input keeps being taken
// while a result waits at the output, as long as an empty stage remains.
// Configuration registers: 0 transition phase, 1 ramp width, 2 first-source
// level, 3 second-source level; other indexes are ignored. Write them only
// while no item is in flight.
module rule_image_transition_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: [31:0] first_pixel, [63:32] second_pixel, [71:64] rule_value
    input  logic [ritb_pkg::InDataW-1:0]  i_s_axis_tdata,
    input  logic                          i_s_axis_tlast,
    // Output stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: [31:0] blended_pixel
    output logic [ritb_pkg::PixW-1:0]     o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    // Configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ritb_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [ritb_pkg::CfgDataW-1:0] i_cfg_data
);

    // Configuration registers
    logic [ritb_pkg::PhaseW-1:0] r_phase;
    logic [ritb_pkg::PhaseW-1:0] r_vague;
    logic [ritb_pkg::LevelW-1:0] r_level1;
    logic [ritb_pkg::LevelW-1:0] r_level2;

    // Pipeline state: stages 1 to 7, the output register is stage 8
    logic                  r_v    [1:7];
    ritb_pkg::t_item       r_item [1:7];
    logic [8:1]            rdy;
    logic [ritb_pkg::PhaseW-1:0] r_d;
    logic [ritb_pkg::NumW-1:0]   r_num;
    ritb_pkg::t_div        r_div  [3:6];
    logic [ritb_pkg::PixW-1:0]   r_step;
    logic                        r_out_v;
    logic [ritb_pkg::PixW-1:0]   r_out_data;
    logic                        r_out_last;

    // Stage 1 decode signals
    logic [ritb_pkg::RuleW-1:0]   in_rule;
    logic signed [ritb_pkg::PhaseW:0] start;
    logic signed [ritb_pkg::PhaseW:0] rule_s;
    logic signed [ritb_pkg::PhaseW:0] rel;
    logic [ritb_pkg::LevelW-1:0]  ramp_end;
    ritb_pkg::t_sel               n_sel;
    ritb_pkg::t_item              n_item0;

    // Stage 7 and output signals
    logic [ritb_pkg::ChanW-1:0]   weight;
    logic [ritb_pkg::PixW-1:0]    n_step;
    logic [ritb_pkg::PixW-1:0]    n_out_data;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ritb_pkg::PHASE_RST;
            r_vague  <= ritb_pkg::RAMP_RST;
            r_level1 <= ritb_pkg::LEVEL1_RST;
            r_level2 <= ritb_pkg::LEVEL2_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ritb_pkg::CFG_PHASE:  r_phase  <= i_cfg_data;
                ritb_pkg::CFG_RAMP:   r_vague  <= i_cfg_data;
                ritb_pkg::CFG_LEVEL1: r_level1 <= i_cfg_data[ritb_pkg::LevelW-1:0];
                ritb_pkg::CFG_LEVEL2: r_level2 <= i_cfg_data[ritb_pkg::LevelW-1:0];
                default: ;
            endcase
        end
    end

    // Flow control: a stage loads when it is empty or its item moves on
    assign rdy[8] = !r_out_v || i_m_axis_tready;
    generate
        for (genvar g = 1; g <= 7; g++) begin : g_rdy
            assign rdy[g] = !r_v[g] || rdy[g+1];
        end
    endgenerate
    assign o_s_axis_tready = rdy[1];

    // Stage 1: classify the rule byte against the levels and the ramp
    always_comb begin
        in_rule  = i_s_axis_tdata[2*ritb_pkg::PixW +: ritb_pkg::RuleW];
        start    = $signed({1'b0, r_phase}) - $signed({1'b0, r_vague});
        rule_s   = $signed({3'b000, in_rule});
        rel      = rule_s - start;
        ramp_end = (r_phase > {1'b0, ritb_pkg::RULE_SPAN}) ? ritb_pkg::RULE_SPAN
                                                          : r_phase[ritb_pkg::LevelW-1:0];
        if ({1'b0, in_rule} >= r_level1) begin
            n_sel = ritb_pkg::SEL_FIRST;
        end else if ({1'b0, in_rule} < r_level2) begin
            n_sel = ritb_pkg::SEL_SECOND;
        end else if (rule_s < start) begin
            n_sel = ritb_pkg::SEL_FULL;
        end else if (({1'b0, in_rule} >= ramp_end) || (r_vague == '0)) begin
            n_sel = ritb_pkg::SEL_ZERO;
        end else begin
            n_sel = ritb_pkg::SEL_RAMP;
        end
        n_item0.p1  = i_s_axis_tdata[0 +: ritb_pkg::PixW];
        n_item0.p2  = i_s_axis_tdata[ritb_pkg::PixW +: ritb_pkg::PixW];
        n_item0.eol = i_s_axis_tlast;
        n_item0.sel = n_sel;
    end

    // Valid bits and the fields that ride along with each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[1] <= 1'b0;
        end else if (rdy[1]) begin
            r_v[1] <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_item[1] <= n_item0;
            r_d       <= rel[ritb_pkg::PhaseW-1:0];
        end
    end

    generate
        for (genvar g = 2; g <= 7; g++) begin : g_stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (rdy[g]) begin
                    r_v[g] <= r_v[g-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (rdy[g]) begin
                    r_item[g] <= r_item[g-1];
                end
            end
        end
    endgenerate

    // Stage 2: dividend is the ramp offset times 255
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_num <= {r_d, ritb_pkg::ChanW'(0)} - {ritb_pkg::ChanW'(0), r_d};
        end
    end

    // Stages 3 to 6: restoring divider by the ramp width, two bits a stage.
    // The quotient stays below 255 because the offset is below the width.
    generate
        for (genvar g = 0; g < ritb_pkg::DivStgs; g++) begin : g_div
            ritb_pkg::t_div          div_in;
            ritb_pkg::t_div          div_out;
            logic [ritb_pkg::PhaseW:0] s0;
            logic [ritb_pkg::PhaseW:0] s1;

            if (g == 0) begin : g_first
                assign div_in.rem = r_num[ritb_pkg::NumW-1:ritb_pkg::QuoW];
                assign div_in.quo = '0;
                assign div_in.lo  = r_num[ritb_pkg::QuoW-1:0];
            end else begin : g_next
                assign div_in = r_div[g+2];
            end

            always_comb begin
                s0 = ritb_pkg::div_step(div_in.rem, div_in.lo[ritb_pkg::QuoW-1], r_vague);
                s1 = ritb_pkg::div_step(s0[ritb_pkg::PhaseW-1:0],
                                        div_in.lo[ritb_pkg::QuoW-2], r_vague);
                div_out.rem = s1[ritb_pkg::PhaseW-1:0];
                div_out.quo = {div_in.quo[ritb_pkg::QuoW-3:0],
                               s0[ritb_pkg::PhaseW], s1[ritb_pkg::PhaseW]};
                div_out.lo  = {div_in.lo[ritb_pkg::QuoW-3:0], 2'b00};
            end

            always_ff @(posedge i_clk) begin
                if (rdy[g+3]) begin
                    r_div[g+3] <= div_out;
                end
            end
        end
    endgenerate

    // Stage 7: weight and the per-channel products (b - a) * w
    always_comb begin
        case (r_item[6].sel)
            ritb_pkg::SEL_RAMP: weight = ritb_pkg::W_FULL - r_div[6].quo;
            ritb_pkg::SEL_FULL: weight = ritb_pkg::W_FULL;
            default:            weight = '0;
        endcase
    end

    generate
        for (genvar c = 0; c < ritb_pkg::NumChan; c++) begin : g_mul
            logic signed [ritb_pkg::ChanW:0]     diff;
            logic signed [2*ritb_pkg::ChanW+1:0] prod;
            assign diff = $signed({1'b0, r_item[6].p2[c*ritb_pkg::ChanW +: ritb_pkg::ChanW]})
                        - $signed({1'b0, r_item[6].p1[c*ritb_pkg::ChanW +: ritb_pkg::ChanW]});
            assign prod = diff * $signed({1'b0, weight});
            // Bits 15..8 are floor(prod / 256) modulo 256
            assign n_step[c*ritb_pkg::ChanW +: ritb_pkg::ChanW] =
                prod[2*ritb_pkg::ChanW-1:ritb_pkg::ChanW];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r_step <= n_step;
        end
    end

    // Output stage: pick a source pixel or add the steps channel by channel
    always_comb begin
        case (r_item[7].sel)
            ritb_pkg::SEL_FIRST:  n_out_data = r_item[7].p1;
            ritb_pkg::SEL_SECOND: n_out_data = r_item[7].p2;
            default: begin
                for (int c = 0; c < ritb_pkg::NumChan; c++) begin
                    n_out_data[c*ritb_pkg::ChanW +: ritb_pkg::ChanW] =
                        r_item[7].p1[c*ritb_pkg::ChanW +: ritb_pkg::ChanW]
                        + r_step[c*ritb_pkg::ChanW +: ritb_pkg::ChanW];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (rdy[8]) begin
            r_out_v <= r_v[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r_out_data <= n_out_data;
            r_out_last <= r_item[7].eol;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // An accepted input item always lands in the first stage
    a_input_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_v[1])
        else $error("accepted item did not enter stage 1");

    // The divider remainder stays below the ramp width for ramp items
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[6] && r_item[6].sel == ritb_pkg::SEL_RAMP) |-> (r_div[6].rem < r_vague))
        else $error("divider remainder out of range");

    // The ramp quotient never reaches full weight, so the weight stays above zero
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[6] && r_item[6].sel == ritb_pkg::SEL_RAMP) |-> (r_div[6].quo != 8'hFF))
        else $error("ramp quotient too large");

    // A zero-select item has zero weight and gives zero steps in every channel
    a_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[7] && r_item[7].sel == ritb_pkg::SEL_ZERO) |-> (r_step == '0))
        else $error("zero weight produced a non-zero step");

    // A first-source item leaves with the first pixel unchanged
    a_first_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rdy[8] && r_v[7] && r_item[7].sel == ritb_pkg::SEL_FIRST)
        |=> (o_m_axis_tdata == $past(r_item[7].p1)))
        else $error("first-source item altered");
`endif

endmodule
